@@ design/lfu_cache_store_assert.svh @@
// Assertion macros for the LFU cache store, sampled on clk, muted in reset.
`ifndef LFU_CACHE_STORE_ASSERT_SVH
`define LFU_CACHE_STORE_ASSERT_SVH

// Same-cycle implication.
`define LCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds on every sampled edge.
`define LCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

@@ design/lcs_pkg.sv @@
// Shared types and constants of the LFU cache store.
`default_nettype none

package lcs_pkg;

  // Fixed field widths.
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Scan token fields sized for the largest store (256 entries, 32-bit counts).
  localparam int IDX_W_MAX  = 8;
  localparam int CNT_W_MAX  = 9;
  localparam int USES_W_MAX = 32;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } out_word_t;

  // Summary that walks down the cell row, one cell per cycle.
  typedef struct packed {
    logic                  found;
    logic [IDX_W_MAX-1:0]  hit_idx;
    logic [IDX_W_MAX-1:0]  hit_age;
    logic [DATA_W-1:0]     hit_data;
    logic [CNT_W_MAX-1:0]  count;
    logic                  vic_vld;
    logic [IDX_W_MAX-1:0]  vic_idx;
    logic [IDX_W_MAX-1:0]  vic_age;
    logic [USES_W_MAX-1:0] vic_uses;
    logic                  free_vld;
    logic [IDX_W_MAX-1:0]  free_idx;
  } scan_tok_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_HIT    = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_op_t;

  // Update broadcast to every cell at the end of an item.
  typedef struct packed {
    cmd_op_t              op;
    logic                 put;
    logic                 evict;
    logic [IDX_W_MAX-1:0] hit_idx;
    logic [IDX_W_MAX-1:0] vic_idx;
    logic [IDX_W_MAX-1:0] slot_idx;
    logic [IDX_W_MAX-1:0] ref_age;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_APPLY = 2'd2
  } ctl_state_t;

endpackage

`default_nettype wire

@@ design/lfu_cache_store.sv @@
// Top level of the LFU cache store: control, capacity register and cell row.
`default_nettype none

`include "lfu_cache_store_assert.svh"

// Fully associative key/value store with least-frequently-used replacement.
// Input channel: a word (action, key, value) is taken at a clock edge where
//   start is high and busy is low. action 0 is a get, 1 is a put.
// Result channel: exactly one word per input word; out_strobe is high for one
//   cycle with out_word (hit, read_value). The receiver cannot stall, so the
//   result is strobed only once; out_word holds it until the next result.
// Config: cfg_we writes cfg_wdata into the capacity register (reset 16);
//   zero acts as one, values above ENTRIES act as ENTRIES. Write only when idle.
// Timing: the entries form a row of ENTRIES cells. A scan token walks the row,
//   one cell per cycle, collecting match, occupancy, LFU victim and first free
//   slot. In the next cycle the decision is registered with the result, and at
//   the end of the strobe cycle the update lands in all cells at once.
//   busy drops at the edge that ends the strobe cycle, so a new word is only
//   taken once the update of the previous one has landed.
// Reset: synchronous active-low rst_n clears every valid bit and the control;
//   the store comes out empty and ready in the next cycle.
module lfu_cache_store #(
  parameter int ENTRIES         = 16,
  parameter int USE_COUNT_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire lcs_pkg::in_word_t          in_word,
  output logic                            out_strobe,
  output lcs_pkg::out_word_t              out_word,
  input  wire logic                       cfg_we,
  input  wire logic [lcs_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int CW = lcs_pkg::CNT_W_MAX;

  lcs_pkg::ctl_state_t          state_r, state_nxt;
  logic [lcs_pkg::CAP_W-1:0]    capacity_r;
  logic                         launch_r, launch_nxt;
  logic                         req_put_r;
  logic [lcs_pkg::KEY_W-1:0]    req_key_r;
  logic [lcs_pkg::DATA_W-1:0]   req_value_r;
  lcs_pkg::cell_cmd_t           cmd_r, cmd_nxt;
  logic                         out_strobe_r, out_strobe_nxt;
  lcs_pkg::out_word_t           out_word_r, out_word_nxt;

  logic                         accept;
  logic [CW-1:0]                cap_eff;
  lcs_pkg::scan_tok_t           last_tok;
  logic                         scan_done;

  // Token chain: slot 0 feeds cell 0, slot ENTRIES is the row's output.
  lcs_pkg::scan_tok_t           tok_chain [ENTRIES+1];
  logic [ENTRIES:0]             vld_chain;

  assign accept       = start && !busy;
  assign busy         = (state_r != lcs_pkg::ST_IDLE);
  assign tok_chain[0] = '0;
  assign vld_chain[0] = launch_r;
  assign last_tok     = tok_chain[ENTRIES];
  assign scan_done    = vld_chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lcs_cell #(
      .IDX             (g),
      .ENTRIES         (ENTRIES),
      .USE_COUNT_WIDTH (USE_COUNT_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .req_key     (req_key_r),
      .req_value   (req_value_r),
      .cmd         (cmd_r),
      .tok_vld_in  (vld_chain[g]),
      .tok_in      (tok_chain[g]),
      .tok_vld_out (vld_chain[g+1]),
      .tok_out     (tok_chain[g+1])
    );
  end

  // Effective capacity: clamp into 1..ENTRIES.
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(capacity_r) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(capacity_r);
    end
  end

  // Sequencer and the decision made when the token leaves the last cell.
  always_comb begin
    state_nxt      = state_r;
    launch_nxt     = 1'b0;
    cmd_nxt        = '0;
    cmd_nxt.op     = lcs_pkg::CMD_NONE;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (start) begin
          launch_nxt = 1'b1;
          state_nxt  = lcs_pkg::ST_SCAN;
        end
      end
      lcs_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt               = lcs_pkg::ST_APPLY;
          out_strobe_nxt          = 1'b1;
          out_word_nxt.hit        = last_tok.found;
          out_word_nxt.read_value = '0;
          cmd_nxt.put             = req_put_r;
          if (last_tok.found) begin
            cmd_nxt.op      = lcs_pkg::CMD_HIT;
            cmd_nxt.hit_idx = last_tok.hit_idx;
            cmd_nxt.ref_age = last_tok.hit_age;
            if (!req_put_r) begin
              out_word_nxt.read_value = last_tok.hit_data;
            end
          end else if (req_put_r) begin
            cmd_nxt.op      = lcs_pkg::CMD_INSERT;
            cmd_nxt.evict   = (last_tok.count >= cap_eff);
            cmd_nxt.vic_idx = last_tok.vic_idx;
            cmd_nxt.ref_age = last_tok.vic_age;
            // lowest hole after eviction: an earlier hole or the victim's slot
            if (cmd_nxt.evict &&
                !(last_tok.free_vld && last_tok.free_idx < last_tok.vic_idx)) begin
              cmd_nxt.slot_idx = last_tok.vic_idx;
            end else begin
              cmd_nxt.slot_idx = last_tok.free_idx;
            end
          end
        end
      end
      lcs_pkg::ST_APPLY: begin
        state_nxt = lcs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lcs_pkg::ST_IDLE;
      launch_r     <= 1'b0;
      cmd_r        <= '0;
      out_strobe_r <= 1'b0;
      capacity_r   <= lcs_pkg::CAP_RESET;
    end else begin
      state_r      <= state_nxt;
      launch_r     <= launch_nxt;
      cmd_r        <= cmd_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept) begin
      req_put_r   <= in_word.action;
      req_key_r   <= in_word.key;
      req_value_r <= in_word.value;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // At most one scan token travels the row.
  `LCS_ASSERT_ALWAYS(a_one_token, $onehot0(vld_chain), "more than one scan token in flight")
  // A result only appears while the item still holds the block busy.
  `LCS_ASSERT_NOW(a_strobe_busy, out_strobe, busy, "result outside the update cycle")
  // The block frees up right after its result.
  `LCS_ASSERT_NEXT(a_free_after, out_strobe, !busy, "busy held after result")
  // A token leaving the row always yields a result next cycle.
  `LCS_ASSERT_NEXT(a_scan_result, scan_done, out_strobe, "scan finished without result")

endmodule

`default_nettype wire

@@ design/lcs_cell.sv @@
// One cache entry: holds its slot, folds itself into the passing scan token.
`default_nettype none

module lcs_cell #(
  parameter int IDX             = 0,
  parameter int ENTRIES         = 16,
  parameter int USE_COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [lcs_pkg::KEY_W-1:0]    req_key,
  input  wire logic [lcs_pkg::DATA_W-1:0]   req_value,
  input  wire lcs_pkg::cell_cmd_t           cmd,
  input  wire logic                         tok_vld_in,
  input  wire lcs_pkg::scan_tok_t           tok_in,
  output logic                              tok_vld_out,
  output lcs_pkg::scan_tok_t                tok_out
);

  localparam int IW    = lcs_pkg::IDX_W_MAX;
  localparam int UW    = lcs_pkg::USES_W_MAX;
  localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                         valid_r, valid_nxt;
  logic [lcs_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [lcs_pkg::DATA_W-1:0]   data_r, data_nxt;
  logic [USE_COUNT_WIDTH-1:0]   uses_r, uses_nxt;
  logic [AGE_W-1:0]             age_r, age_nxt;
  logic                         tok_vld_r;
  lcs_pkg::scan_tok_t           tok_r, tok_nxt;

  logic [AGE_W-1:0]             ref_age;
  logic [AGE_W-1:0]             tok_vic_age;
  logic [USE_COUNT_WIDTH-1:0]   tok_vic_uses;

  assign ref_age      = cmd.ref_age[AGE_W-1:0];
  assign tok_vic_age  = tok_in.vic_age[AGE_W-1:0];
  assign tok_vic_uses = tok_in.vic_uses[USE_COUNT_WIDTH-1:0];

  // Scan: count, first key match, LFU victim (ties: older, then lower index), first hole.
  always_comb begin
    tok_nxt = tok_in;
    if (valid_r) begin
      tok_nxt.count = tok_in.count + lcs_pkg::CNT_W_MAX'(1);
      if (!tok_in.found && key_r == req_key) begin
        tok_nxt.found    = 1'b1;
        tok_nxt.hit_idx  = MY_IDX;
        tok_nxt.hit_age  = IW'(age_r);
        tok_nxt.hit_data = data_r;
      end
      if (!tok_in.vic_vld || uses_r < tok_vic_uses ||
          (uses_r == tok_vic_uses && age_r > tok_vic_age)) begin
        tok_nxt.vic_vld  = 1'b1;
        tok_nxt.vic_idx  = MY_IDX;
        tok_nxt.vic_age  = IW'(age_r);
        tok_nxt.vic_uses = UW'(uses_r);
      end
    end else if (!tok_in.free_vld) begin
      tok_nxt.free_vld = 1'b1;
      tok_nxt.free_idx = MY_IDX;
    end
  end

  // Update from the broadcast command.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    uses_nxt  = uses_r;
    age_nxt   = age_r;
    case (cmd.op)
      lcs_pkg::CMD_HIT: begin
        if (cmd.hit_idx == MY_IDX) begin
          if (cmd.put) begin
            data_nxt = req_value;
          end
          if (uses_r != '1) begin
            uses_nxt = uses_r + USE_COUNT_WIDTH'(1);
          end
          age_nxt = '0;
        end else if (valid_r && age_r < ref_age) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end
      lcs_pkg::CMD_INSERT: begin
        if (cmd.slot_idx == MY_IDX) begin
          valid_nxt = 1'b1;
          key_nxt   = req_key;
          data_nxt  = req_value;
          uses_nxt  = USE_COUNT_WIDTH'(1);
          age_nxt   = '0;
        end else if (cmd.evict && cmd.vic_idx == MY_IDX) begin
          valid_nxt = 1'b0;
        end else if (valid_r && !(cmd.evict && age_r > ref_age)) begin
          // entries younger than the evicted one only age by the insert
          age_nxt = age_r + AGE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
    uses_r <= uses_nxt;
    age_r  <= age_nxt;
    tok_r  <= tok_nxt;
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

`default_nettype wire
